@@ rtl/ghash_pkg.sv @@
// ghash_pkg: item types, mode codes and GF(2^128) helpers for the GHASH engine.
// Standalone package; used by ghash_gf128_accumulator.
package ghash_pkg;

   // item modes
   localparam logic [1:0] MODE_ASSOC  = 2'd0;
   localparam logic [1:0] MODE_TEXT   = 2'd1;
   localparam logic [1:0] MODE_FINISH = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // register indexes (byte address 8*i)
   localparam logic REG_KEY_HI = 1'b0;
   localparam logic REG_KEY_LO = 1'b1;

   localparam int         BLOCK_BYTES = 16;
   localparam logic [7:0] GF_REDUCE   = 8'hE1;  // reflected x^7+x^2+x+1

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] block_hi;
      logic [63:0] block_lo;
      logic [4:0]  byte_count;
   } req_type;

   typedef struct packed {
      logic [63:0] hash_hi;
      logic [63:0] hash_lo;
   } rsp_type;

   // Keep the leading byte_count bytes, zero the rest (counts above 16 keep all).
   function automatic logic [127:0] block_mask(input logic [4:0] byte_count);
      logic [127:0] m;
      m = '0;
      for (int b = 0; b < BLOCK_BYTES; b++) begin
         m[127 - 8*b -: 8] = (5'(b) < byte_count) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

   // GF(2^128) product, GCM bit order: vector bit 127 is the x^0 coefficient.
   // Carry-less product then two reduction folds.
   function automatic logic [127:0] gf_mul_reflected(input logic [127:0] x,
                                                     input logic [127:0] h);
      logic [254:0] p;
      logic [133:0] r;
      logic [127:0] z;
      p = '0;
      for (int i = 0; i < 128; i++) begin
         for (int j = 0; j < 128; j++) begin
            p[i+j] = p[i+j] ^ (x[127-i] & h[127-j]);
         end
      end
      r = {6'd0, p[127:0]};
      for (int k = 128; k < 255; k++) begin
         for (int t = 0; t < 8; t++) begin
            if (GF_REDUCE[7-t]) r[k-128+t] = r[k-128+t] ^ p[k];
         end
      end
      for (int k = 128; k < 134; k++) begin
         for (int t = 0; t < 8; t++) begin
            if (GF_REDUCE[7-t]) r[k-128+t] = r[k-128+t] ^ r[k];
         end
      end
      for (int d = 0; d < 128; d++) begin
         z[127-d] = r[d];
      end
      return z;
   endfunction

endpackage

@@ rtl/ghash_gf128_accumulator.sv @@
// ghash_gf128_accumulator: GCM GHASH engine with APB key registers; uses ghash_pkg.
// Into an empty queue, a finish's hash is on rsp_data the cycle after it is taken.
// One item per cycle while req_ready is high: the GF multiply is combinational.
// A two-entry result queue keeps req_ready high while up to one hash waits.
// Reset (synchronous, active high) clears key, accumulator, bit lengths and queue.
module ghash_gf128_accumulator
   import ghash_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   // key registers
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   // ---------------------------------------------------------------
   // Key registers (hash subkey H)
   // ---------------------------------------------------------------
   logic [63:0] key_hi_ff, key_hi_in;
   logic [63:0] key_lo_ff, key_lo_in;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;

   always_comb begin
      key_hi_in = key_hi_ff;
      key_lo_in = key_lo_ff;
      if (csr_write) begin
         case (paddr[3])
            REG_KEY_HI: key_hi_in = pwdata;
            REG_KEY_LO: key_lo_in = pwdata;
            default:    ;
         endcase
      end
   end

   assign prdata = (paddr[3] == REG_KEY_LO) ? key_lo_ff : key_hi_ff;

   // ---------------------------------------------------------------
   // Hash state
   // ---------------------------------------------------------------
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  assoc_len_ff, assoc_len_in;
   logic [63:0]  text_len_ff, text_len_in;

   logic         req_fire;
   logic         is_finish;
   logic         is_block;
   logic [4:0]   eff_count;
   logic [127:0] mul_in;
   logic [127:0] mul_out;
   logic [63:0]  len_add;

   assign req_fire  = req_valid & req_ready;
   assign is_finish = req_data.mode == MODE_FINISH;
   // zero byte count and the unused mode leave the state alone
   assign is_block  = ((req_data.mode == MODE_ASSOC) || (req_data.mode == MODE_TEXT))
                      && (req_data.byte_count != 5'd0);

   assign eff_count = (req_data.byte_count > 5'(BLOCK_BYTES)) ? 5'(BLOCK_BYTES)
                                                              : req_data.byte_count;
   assign len_add   = {56'd0, eff_count, 3'd0};

   // finish folds in the length block, a block item its masked data
   assign mul_in  = is_finish
                  ? (acc_ff ^ {assoc_len_ff, text_len_ff})
                  : (acc_ff ^ ({req_data.block_hi, req_data.block_lo}
                               & block_mask(req_data.byte_count)));
   assign mul_out = gf_mul_reflected(mul_in, {key_hi_ff, key_lo_ff});

   always_comb begin
      acc_in       = acc_ff;
      assoc_len_in = assoc_len_ff;
      text_len_in  = text_len_ff;
      if (req_fire) begin
         if (is_finish) begin
            acc_in       = '0;
            assoc_len_in = '0;
            text_len_in  = '0;
         end else if (is_block) begin
            acc_in = mul_out;
            if (req_data.mode == MODE_ASSOC) assoc_len_in = assoc_len_ff + len_add;
            else                             text_len_in  = text_len_ff + len_add;
         end
      end
   end

   // ---------------------------------------------------------------
   // Result queue, two entries
   // ---------------------------------------------------------------
   rsp_type     q_ff [2];
   rsp_type     q_in;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push;
   logic        pop;

   assign push      = req_fire & is_finish;
   assign pop       = rsp_valid & rsp_ready;
   assign q_in      = mul_out;
   assign req_ready = cnt_ff != 2'd2;
   assign rsp_valid = cnt_ff != 2'd0;
   assign rsp_data  = q_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      cnt_in = cnt_ff;
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff    <= '0;
         key_lo_ff    <= '0;
         acc_ff       <= '0;
         assoc_len_ff <= '0;
         text_len_ff  <= '0;
         wr_ptr_ff    <= 1'b0;
         rd_ptr_ff    <= 1'b0;
         cnt_ff       <= 2'd0;
      end else begin
         key_hi_ff    <= key_hi_in;
         key_lo_ff    <= key_lo_in;
         acc_ff       <= acc_in;
         assoc_len_ff <= assoc_len_in;
         text_len_ff  <= text_len_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         cnt_ff       <= cnt_in;
      end
   end

   // hash payload, no reset needed
   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= q_in;
   end

`ifndef SYNTHESIS
   // queue occupancy never passes its depth
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result queue count out of range");

   // a finish leaves a clean state behind
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_finish) |=>
         (acc_ff == '0) && (assoc_len_ff == '0) && (text_len_ff == '0))
      else $error("state not cleared after finish");

   // ignored items leave accumulator and lengths untouched
   a_ignored_stable: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !is_finish && !is_block) |=>
         (acc_ff == $past(acc_ff)) && (assoc_len_ff == $past(assoc_len_ff))
         && (text_len_ff == $past(text_len_ff)))
      else $error("ignored item changed hash state");

   // a result pushed into an empty queue shows up at once
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      (push && (cnt_ff == 2'd0)) |=> rsp_valid && (rsp_data == $past(mul_out)))
      else $error("pushed hash not presented");
`endif

endmodule

@@ tb/sv/ghash_accum_checker.sv @@
// ghash_accum_checker: watches the item, result and key-register ports of the GHASH
// engine, predicts each hash from its own GF(2^128) model and compares. Uses ghash_pkg.
`timescale 1ns / 1ps

module ghash_accum_checker
   import ghash_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [63:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          hashes_due
);

   logic [127:0] hash_key;
   logic [127:0] acc;
   logic [63:0]  assoc_bits;
   logic [63:0]  text_bits;
   rsp_type      hash_queue[$];

   // reflected shift-and-add multiply by the hash key
   function automatic logic [127:0] ghash_mul_by_key(input logic [127:0] x,
                                                     input logic [127:0] h);
      logic [127:0] z;
      logic [127:0] v;
      logic         lsb;
      z = '0;
      v = h;
      for (int i = 0; i < 128; i++) begin
         if (x[127 - i]) z = z ^ v;
         lsb = v[0];
         v = v >> 1;
         if (lsb) v[127:120] = v[127:120] ^ GF_REDUCE;
      end
      return z;
   endfunction

   task automatic absorb_item(input req_type it);
      logic [127:0] blk;
      logic [4:0]   n;
      rsp_type      h;
      if (it.mode == MODE_FINISH) begin
         acc = ghash_mul_by_key(acc ^ {assoc_bits, text_bits}, hash_key);
         h.hash_hi = acc[127:64];
         h.hash_lo = acc[63:0];
         hash_queue.push_back(h);
         acc = '0;
         assoc_bits = '0;
         text_bits = '0;
      end else if (it.mode != MODE_UNUSED && it.byte_count != 5'd0) begin
         n = (it.byte_count > 5'(BLOCK_BYTES)) ? 5'(BLOCK_BYTES) : it.byte_count;
         blk = {it.block_hi, it.block_lo};
         for (int b = 0; b < BLOCK_BYTES; b++) begin
            if (5'(b) >= n) blk[127 - 8*b -: 8] = 8'h00;
         end
         if (it.mode == MODE_ASSOC) assoc_bits = assoc_bits + 64'(n) * 64'd8;
         else text_bits = text_bits + 64'(n) * 64'd8;
         acc = ghash_mul_by_key(acc ^ blk, hash_key);
      end
   endtask

   initial begin
      fail_count = 0;
      hashes_due = 0;
      hash_key = '0;
      acc = '0;
      assoc_bits = '0;
      text_bits = '0;
   end

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         hash_key = '0;
         acc = '0;
         assoc_bits = '0;
         text_bits = '0;
         hash_queue.delete();
      end else begin
         // results first: a hash never leaves on the edge its finish is taken
         if (rsp_valid && rsp_ready) begin
            if (hash_queue.size() == 0) begin
               $display("%0t: unexpected hash %h_%h", $time,
                        rsp_data.hash_hi, rsp_data.hash_lo);
               fail_count++;
            end else begin
               want = hash_queue.pop_front();
               if (rsp_data.hash_hi !== want.hash_hi) begin
                  $display("%0t: hash_hi expected %h actual %h", $time,
                           want.hash_hi, rsp_data.hash_hi);
                  fail_count++;
               end
               if (rsp_data.hash_lo !== want.hash_lo) begin
                  $display("%0t: hash_lo expected %h actual %h", $time,
                           want.hash_lo, rsp_data.hash_lo);
                  fail_count++;
               end
            end
         end
         if (psel && penable && pwrite && pready && paddr[2:0] == 3'd0) begin
            if (paddr[3] == REG_KEY_HI) hash_key[127:64] = pwdata;
            else hash_key[63:0] = pwdata;
         end
         if (req_valid && req_ready) absorb_item(req_data);
      end
      hashes_due = hash_queue.size();
   end

endmodule

@@ tb/sv/ghash_gf128_accumulator_test.sv @@
// ghash_gf128_accumulator_test: top of the GHASH engine testbench; drives items,
// key writes and result back-pressure. Needs ghash_pkg, the engine and ghash_accum_checker.
`timescale 1ns / 1ps

module ghash_gf128_accumulator_test;
   import ghash_pkg::*;

   localparam logic [63:0] ONES = '1;
   localparam int HOLD_CYCLES = 300;     // long receiver hold-off
   localparam int PHASE_ITEMS = 300;     // counted items per key setting

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;

   int   fail_count;
   int   hashes_due;
   int   items_sent;     // items that change state or give a hash
   bit   quiet;          // no idling on either side while set
   bit   hold_go;        // asks the receiver for one long hold-off
   logic [127:0] phase_key[5];

   ghash_gf128_accumulator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   ghash_accum_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .fail_count (fail_count),
      .hashes_due (hashes_due)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // hard stop, far beyond the slowest correct run
   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic req_type item_of(input logic [1:0] mode, input logic [63:0] hi,
                                       input logic [63:0] lo, input logic [4:0] cnt);
      req_type it;
      it.mode = mode;
      it.block_hi = hi;
      it.block_lo = lo;
      it.byte_count = cnt;
      return it;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Offer one item from a falling edge and hold it until it is taken.
   // Valid stays high into the next call when no idle cycle is drawn.
   task automatic send_item(input req_type item);
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (item.mode == MODE_FINISH ||
          (item.mode != MODE_UNUSED && item.byte_count != 5'd0))
         items_sent++;
   endtask

   // Drop valid, wait for every hash to come back, and idle before returning so
   // the last block has surely been folded in.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (hashes_due != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // APB write: setup cycle, then access cycle; lands on the edge with pready high
   task automatic write_reg(input logic idx, input logic [63:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic load_key(input logic [127:0] key);
      drain();
      write_reg(REG_KEY_HI, key[127:64]);
      write_reg(REG_KEY_LO, key[63:0]);
   endtask

   // One well-formed message: assoc blocks, text blocks, finish.
   // Only the last block of a section is ever short.
   task automatic send_message(input int max_assoc, input int max_text);
      int n_assoc;
      int n_text;
      logic [4:0] cnt;
      n_assoc = $urandom_range(0, max_assoc);
      n_text = $urandom_range(0, max_text);
      for (int i = 0; i < n_assoc; i++) begin
         cnt = (i == n_assoc - 1 && $urandom_range(0, 2) == 0) ?
               5'($urandom_range(1, 15)) : 5'd16;
         send_item(item_of(MODE_ASSOC, rand64(), rand64(), cnt));
      end
      for (int i = 0; i < n_text; i++) begin
         cnt = (i == n_text - 1 && $urandom_range(0, 2) == 0) ?
               5'($urandom_range(1, 15)) : 5'd16;
         send_item(item_of(MODE_TEXT, rand64(), rand64(), cnt));
      end
      send_item(item_of(MODE_FINISH, rand64(), rand64(), 5'($urandom_range(0, 31))));
   endtask

   // Mostly messages; about one pick in seven is a noise item with any mode and count.
   task automatic run_traffic(input int target);
      int start;
      start = items_sent;
      while (items_sent - start < target) begin
         if ($urandom_range(0, 99) < 15)
            send_item(item_of(2'($urandom_range(0, 3)), rand64(), rand64(),
                              5'($urandom_range(0, 31))));
         else
            send_message(3, 5);
      end
   endtask

   // Receiver: random stalls, none while quiet, and one long hold-off on request.
   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_go) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_go = 1'b0;
         end else begin
            rsp_ready <= quiet || ($urandom_range(0, 99) >= 20);
         end
      end
   end

   initial begin : stimulus
      int guard;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      items_sent = 0;
      quiet = 1'b0;
      hold_go = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // key still zero after reset: hash of an empty message
      send_item(item_of(MODE_FINISH, ONES, ONES, 5'd16));

      // directed part under a known key
      load_key({64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e});
      send_item(item_of(MODE_ASSOC, ONES, ONES, 5'd16));
      send_item(item_of(MODE_ASSOC, ONES, ONES, 5'd1));
      send_item(item_of(MODE_TEXT, ONES, ONES, 5'd7));
      send_item(item_of(MODE_TEXT, ONES, ONES, 5'd8));
      send_item(item_of(MODE_TEXT, ONES, ONES, 5'd9));
      send_item(item_of(MODE_TEXT, ONES, ONES, 5'd15));
      // ignored: zero count, then the unused mode
      send_item(item_of(MODE_TEXT, ONES, ONES, 5'd0));
      send_item(item_of(MODE_UNUSED, ONES, ONES, 5'd16));
      // finish with junk in the ignored fields
      send_item(item_of(MODE_FINISH, ONES, ONES, 5'd31));
      // short block that is not last in its section
      send_item(item_of(MODE_TEXT, ONES, ONES, 5'd5));
      send_item(item_of(MODE_TEXT, ONES, 64'h0123456789abcdef, 5'd16));
      // counts above sixteen act as sixteen
      send_item(item_of(MODE_ASSOC, 64'hfedcba9876543210, ONES, 5'd17));
      send_item(item_of(MODE_TEXT, ONES, ONES, 5'd31));
      send_item(item_of(MODE_FINISH, '0, '0, 5'd0));
      // back-to-back finish on cleared state
      send_item(item_of(MODE_FINISH, '0, '0, 5'd16));
      send_item(item_of(MODE_ASSOC, '0, '0, 5'd16));
      send_item(item_of(MODE_TEXT, '0, '0, 5'd16));
      send_item(item_of(MODE_FINISH, '0, '0, 5'd16));

      // random part under several keys, extremes among them
      phase_key[0] = {rand64(), rand64()};
      phase_key[1] = {ONES, ONES};
      phase_key[2] = '0;
      phase_key[3] = {64'h8000000000000000, 64'h0};   // multiplicative identity
      phase_key[4] = {rand64(), rand64()};
      for (int p = 0; p < 5; p++) begin
         load_key(phase_key[p]);
         quiet = (p == 1);
         if (p == 3) begin
            // receiver holds off while finishes pile up and stall the input
            hold_go = 1'b1;
            for (int i = 0; i < 12; i++) begin
               send_item(item_of(MODE_TEXT, rand64(), rand64(), 5'd16));
               send_item(item_of(MODE_FINISH, rand64(), rand64(), 5'd16));
            end
         end
         run_traffic(PHASE_ITEMS);
         quiet = 1'b0;
      end

      // wait for the last hashes, bounded
      @(negedge clock);
      req_valid <= 1'b0;
      guard = 0;
      while (hashes_due != 0 && guard < 10000) begin
         @(negedge clock);
         guard++;
      end
      repeat (8) @(negedge clock);
      if (fail_count == 0 && hashes_due == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ files.f @@
rtl/ghash_pkg.sv
rtl/ghash_gf128_accumulator.sv
tb/sv/ghash_accum_checker.sv
tb/sv/ghash_gf128_accumulator_test.sv
